// ----- sv/bjt_pkg.sv -----
// bjt_pkg: widths, fixed-point constants and shared structs of the Bessel J1 evaluator.
// No dependencies; used by the channel interfaces, bjt_horner and the top level.
package bjt_pkg;

  // series length; one Horner iteration per term after the first
  localparam int unsigned NUM_TERMS = 20;
  localparam int unsigned N_ITER    = NUM_TERMS - 1;

  localparam int unsigned XW       = 32;  // argument, Q3.28
  localparam int unsigned OW       = 32;  // result, Q1.30
  localparam int unsigned FRAC     = 40;  // fraction bits of y and s
  localparam int unsigned SQ_SHIFT = 18;  // Q.56 square / 4 -> Q.40
  localparam int unsigned YW       = 45;  // y = x*x/4 <= 16.0
  localparam int unsigned SW       = 48;  // |s| stays far below 2^47
  localparam int unsigned NW       = 52;  // rounded product plus half divisor
  localparam int unsigned MW       = NW + 1;  // reciprocal width

  // operand splits for the partial products
  localparam int unsigned YL = 24;
  localparam int unsigned YH = YW - YL;
  localparam int unsigned SL = 24;
  localparam int unsigned SH = SW - SL;
  localparam int unsigned NL = 26;
  localparam int unsigned NH = NW - NL;
  localparam int unsigned ML = 26;
  localparam int unsigned MH = MW - ML;

  localparam int unsigned PW  = YW + SW + 1;     // y*|s| sum
  localparam int unsigned QPW = NW + MW + 1;     // n*m sum
  localparam int unsigned FPW = XW + SW + 1;     // |x|*|s| sum
  localparam int unsigned RW  = FPW - (FRAC - 1); // unsaturated result magnitude

  localparam logic [SW-1:0] ONE_Q   = SW'(1) << FRAC;
  localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW - 1){1'b1}}};
  localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW - 1){1'b0}}};

  // fields that ride along the iterations unchanged
  typedef struct packed {
    logic          last;
    logic          x_neg;
    logic [XW-1:0] x_mag;
    logic [YW-1:0] y;
  } bjt_side_t;

  // Horner state between iterations
  typedef struct packed {
    bjt_side_t     side;
    logic          s_neg;
    logic [SW-1:0] s_mag;
  } bjt_hs_t;

endpackage

// ----- sv/bjt_in_if.sv -----
// bjt_in_if: argument channel, valid/ready with x_value and last_in.
// Depends on bjt_pkg for the argument width.
interface bjt_in_if;
  import bjt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] x_value;
  logic                 last_in;

  modport source (output valid, output x_value, output last_in, input ready);
  modport sink (input valid, input x_value, input last_in, output ready);
endinterface

// ----- sv/bjt_out_if.sv -----
// bjt_out_if: result channel, valid/ready with j1_value and last_out.
// Depends on bjt_pkg for the result width.
interface bjt_out_if;
  import bjt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [OW-1:0] j1_value;
  logic                 last_out;

  modport source (output valid, output j1_value, output last_out, input ready);
  modport sink (input valid, input j1_value, input last_out, output ready);
endinterface

// ----- sv/bjt_horner.sv -----
// bjt_horner: Horner recurrence s = 1 - y*s/(k(k+1)), k = N_ITER down to 1,
// five register stages per iteration. Depends on bjt_pkg.
module bjt_horner (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  bjt_pkg::bjt_hs_t hs_in,
  output logic            vld_out,
  output bjt_pkg::bjt_hs_t hs_out
);
  import bjt_pkg::*;

  logic    vld [0:N_ITER];
  bjt_hs_t hs  [0:N_ITER];

  assign vld[0]  = vld_in;
  assign hs[0]   = hs_in;
  assign vld_out = vld[N_ITER];
  assign hs_out  = hs[N_ITER];

  for (genvar i = 0; i < N_ITER; i++) begin : g_it
    localparam int unsigned     K     = N_ITER - i;
    localparam longint unsigned DIV   = 64'(K * (K + 1));
    localparam int unsigned     LSH   = $clog2(DIV);
    localparam int unsigned     SHIFT = NW + LSH;
    // exact floor(n / DIV) for n < 2^NW
    localparam longint unsigned MUL   = ((64'd1 << SHIFT) + DIV - 64'd1) / DIV;
    localparam longint unsigned HALF  = DIV / 2;
    localparam logic [ML-1:0]   M_LO  = ML'(MUL);
    localparam logic [MH-1:0]   M_HI  = MH'(MUL >> ML);
    localparam logic [PW-1:0]   B_RND = (PW'(HALF) << FRAC) + (PW'(1) << (FRAC - 1));

    // A: partial products of y * |s|
    logic              a_vld;
    bjt_side_t         a_side;
    logic              a_sneg;
    logic [YL+SL-1:0]  a_pll;
    logic [YL+SH-1:0]  a_plh;
    logic [YH+SL-1:0]  a_phl;
    logic [YH+SH-1:0]  a_phh;
    // B: n = round(y*|s|) + DIV/2
    logic              b_vld;
    bjt_side_t         b_side;
    logic              b_sneg;
    logic [NW-1:0]     b_n;
    logic [PW-1:0]     b_sum;
    // C: partial products of n * reciprocal
    logic              c_vld;
    bjt_side_t         c_side;
    logic              c_sneg;
    logic [NL+ML-1:0]  c_pll;
    logic [NL+MH-1:0]  c_plh;
    logic [NH+ML-1:0]  c_phl;
    logic [NH+MH-1:0]  c_phh;
    // D: quotient
    logic              d_vld;
    bjt_side_t         d_side;
    logic              d_sneg;
    logic [SW-1:0]     d_q;
    logic [QPW-1:0]    d_sum;
    // E: new s in sign/magnitude
    logic              e_vld;
    bjt_hs_t           e_hs;
    bjt_hs_t           e_hs_next;

    always_ff @(posedge clk) begin
      if (rst) begin
        a_vld <= 1'b0;
        b_vld <= 1'b0;
        c_vld <= 1'b0;
        d_vld <= 1'b0;
        e_vld <= 1'b0;
      end else if (en) begin
        a_vld <= vld[i];
        b_vld <= a_vld;
        c_vld <= b_vld;
        d_vld <= c_vld;
        e_vld <= d_vld;
      end
    end

    assign b_sum = PW'(a_pll) + (PW'(a_plh) << SL) + (PW'(a_phl) << YL)
                 + (PW'(a_phh) << (YL + SL)) + B_RND;

    assign d_sum = QPW'(c_pll) + (QPW'(c_plh) << ML) + (QPW'(c_phl) << NL)
                 + (QPW'(c_phh) << (NL + ML));

    always_comb begin
      e_hs_next.side = d_side;
      if (d_sneg) begin
        e_hs_next.s_neg = 1'b0;
        e_hs_next.s_mag = ONE_Q + d_q;
      end else if (d_q > ONE_Q) begin
        e_hs_next.s_neg = 1'b1;
        e_hs_next.s_mag = d_q - ONE_Q;
      end else begin
        e_hs_next.s_neg = 1'b0;
        e_hs_next.s_mag = ONE_Q - d_q;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_side <= hs[i].side;
        a_sneg <= hs[i].s_neg;
        a_pll  <= hs[i].side.y[YL-1:0]  * hs[i].s_mag[SL-1:0];
        a_plh  <= hs[i].side.y[YL-1:0]  * hs[i].s_mag[SW-1:SL];
        a_phl  <= hs[i].side.y[YW-1:YL] * hs[i].s_mag[SL-1:0];
        a_phh  <= hs[i].side.y[YW-1:YL] * hs[i].s_mag[SW-1:SL];

        b_side <= a_side;
        b_sneg <= a_sneg;
        b_n    <= NW'(b_sum >> FRAC);

        c_side <= b_side;
        c_sneg <= b_sneg;
        c_pll  <= b_n[NL-1:0]  * M_LO;
        c_plh  <= b_n[NL-1:0]  * M_HI;
        c_phl  <= b_n[NW-1:NL] * M_LO;
        c_phh  <= b_n[NW-1:NL] * M_HI;

        d_side <= c_side;
        d_sneg <= c_sneg;
        d_q    <= SW'(d_sum >> SHIFT);

        e_hs   <= e_hs_next;
      end
    end

    assign vld[i+1] = e_vld;
    assign hs[i+1]  = e_hs;
  end

endmodule

// ----- sv/bessel_j1_taylor_eval.sv -----
// bessel_j1_taylor_eval: streaming J1(x) from a truncated Maclaurin series in x*x/4.
// Depends on bjt_pkg, bjt_in_if, bjt_out_if and bjt_horner.
//
// Usage:
//   arg    : sink of x_value (signed Q3.28) and last_in; transfer on valid & ready.
//   result : source of j1_value (signed Q1.30, saturated) and last_out.
//   One result per argument, in order; last_out copies last_in.
//   From the argument transfer to the result being offered, an item passes the
//   input register, square, scale, five stages per Horner iteration (product,
//   round, reciprocal product, quotient, update), then final product, round
//   and saturate.
//   Throughput is one item per cycle while the receiver takes results.
//   The pipeline advances as one; a two-deep output (tail register plus skid
//   register) lets the tail hand off while the receiver stalls, and
//   arg.ready is low only during reset or while the skid register is full.
//   Synchronous reset clears all valid bits, including the skid register's;
//   arg.ready is high as soon as reset is released.
//   Accuracy targets |x| <= 6; larger arguments still give the same
//   deterministic truncated-series answer.
module bessel_j1_taylor_eval (
  input logic      clk,
  input logic      rst,
  bjt_in_if.sink   arg,
  bjt_out_if.source result
);
  import bjt_pkg::*;

  logic en;

  // input register
  logic          s0_vld;
  logic          s0_last;
  logic          s0_neg;
  logic [XW-1:0] s0_mag;
  // square
  logic            s1_vld;
  logic            s1_last;
  logic            s1_neg;
  logic [XW-1:0]   s1_mag;
  logic [2*XW-1:0] s1_sq;
  // y, start of Horner
  logic    s2_vld;
  bjt_hs_t s2_hs;
  // Horner result
  logic    h_vld;
  bjt_hs_t h_hs;
  // final product
  logic             f1_vld;
  logic             f1_last;
  logic             f1_rneg;
  logic [XW+SL-1:0] f1_plo;
  logic [XW+SH-1:0] f1_phi;
  logic [FPW-1:0]   f2_sum;
  logic             f2_vld;
  logic             f2_last;
  logic             f2_rneg;
  logic [RW-1:0]    f2_r;
  logic             f3_vld;
  logic             f3_last;
  logic [OW-1:0]    f3_j1;
  logic [OW-1:0]    f3_j1_next;
  // skid
  logic          skid_vld;
  logic          skid_last;
  logic [OW-1:0] skid_j1;

  assign en        = !skid_vld;
  assign arg.ready = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      f1_vld <= 1'b0;
      f2_vld <= 1'b0;
      f3_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= arg.valid;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
      f1_vld <= h_vld;
      f2_vld <= f1_vld;
      f3_vld <= f2_vld;
    end
  end

  assign f2_sum = FPW'(f1_plo) + (FPW'(f1_phi) << SL) + (FPW'(1) << (FRAC - 2));

  always_comb begin
    if (f2_rneg) begin
      if (f2_r > RW'(SAT_NEG)) begin
        f3_j1_next = SAT_NEG;
      end else begin
        f3_j1_next = OW'(~f2_r[OW-1:0] + 1'b1);
      end
    end else if (f2_r > RW'(SAT_POS)) begin
      f3_j1_next = SAT_POS;
    end else begin
      f3_j1_next = f2_r[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_last <= arg.last_in;
      s0_neg  <= arg.x_value[XW-1];
      s0_mag  <= arg.x_value[XW-1] ? XW'(~arg.x_value + 1'b1) : arg.x_value;

      s1_last <= s0_last;
      s1_neg  <= s0_neg;
      s1_mag  <= s0_mag;
      s1_sq   <= s0_mag * s0_mag;

      s2_hs.side.last  <= s1_last;
      s2_hs.side.x_neg <= s1_neg;
      s2_hs.side.x_mag <= s1_mag;
      s2_hs.side.y     <= YW'((s1_sq + ((2 * XW)'(1) << (SQ_SHIFT - 1))) >> SQ_SHIFT);
      s2_hs.s_neg      <= 1'b0;
      s2_hs.s_mag      <= ONE_Q;

      f1_last <= h_hs.side.last;
      f1_rneg <= h_hs.s_neg ^ h_hs.side.x_neg;
      f1_plo  <= h_hs.side.x_mag * h_hs.s_mag[SL-1:0];
      f1_phi  <= h_hs.side.x_mag * h_hs.s_mag[SW-1:SL];

      f2_last <= f1_last;
      f2_rneg <= f1_rneg;
      f2_r    <= RW'(f2_sum >> (FRAC - 1));

      f3_last <= f2_last;
      f3_j1   <= f3_j1_next;
    end
  end

  bjt_horner u_horner (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (s2_vld),
    .hs_in   (s2_hs),
    .vld_out (h_vld),
    .hs_out  (h_hs)
  );

  // tail result not taken while advancing: park it
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (result.ready) begin
        skid_vld <= 1'b0;
      end
    end else if (f3_vld && !result.ready) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld) begin
      skid_last <= f3_last;
      skid_j1   <= f3_j1;
    end
  end

  assign result.valid    = skid_vld || f3_vld;
  assign result.j1_value = skid_vld ? skid_j1 : f3_j1;
  assign result.last_out = skid_vld ? skid_last : f3_last;

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_vld) |-> $past(f3_vld && !result.ready))
    else $error("skid filled without a stalled tail result");

  a_tail_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_vld |=> $stable(f3_vld) && $stable(f3_j1) && $stable(f3_last))
    else $error("pipeline tail moved while skid register was full");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && skid_vld |=> !skid_vld)
    else $error("skid register not released after transfer");

endmodule

// ----- dv/bessel_j1_taylor_eval_test.sv -----
`timescale 1ns / 100ps
// bessel_j1_taylor_eval_test: streams Q3.28 arguments through the J1 evaluator and checks
// each Q1.30 result and last flag against a bit-true fixed-point Horner predictor.
// Depends on bjt_pkg, bjt_in_if, bjt_out_if and the bessel_j1_taylor_eval RTL.
module bessel_j1_taylor_eval_test;
  import bjt_pkg::*;

  localparam int unsigned PIPE_LATENCY = 5 * (NUM_TERMS - 1) + 6;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned FLOOD_ITEMS  = 160;
  localparam longint      S_ONE        = longint'(1) << FRAC;
  localparam longint      S_CAP        = longint'(1) << 62;
  localparam longint      X_SIX        = longint'(6) << 28;
  localparam real         Q28          = 268435456.0;

  typedef struct packed {
    logic [OW-1:0] j1;
    logic          last;
  } j1_result_t;

  logic clk;
  logic rst;

  bjt_in_if  arg_if ();
  bjt_out_if res_if ();

  j1_result_t  j1_expected_q[$];
  int unsigned err_count       = 0;
  int unsigned src_idle_pct    = 0;
  int unsigned dst_idle_pct    = 0;
  int unsigned rcv_hold_cycles = 0;
  int unsigned quiet_cycles    = 0;

  bessel_j1_taylor_eval dut (
    .clk    (clk),
    .rst    (rst),
    .arg    (arg_if),
    .result (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round half up of a*b / 2^sh, clamped to cap
  function automatic logic [63:0] round_product(input logic [63:0] a, input logic [63:0] b,
                                                input int unsigned sh, input logic [63:0] cap);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
    return (p > {64'd0, cap}) ? cap : p[63:0];
  endfunction

  function automatic logic [OW-1:0] j1_series(input logic [XW-1:0] xraw);
    logic        x_neg;
    logic        s_neg;
    logic        r_neg;
    logic [63:0] x_mag;
    logic [63:0] y;
    logic [63:0] s_mag;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] d;
    logic [63:0] r_mag;
    longint      s;
    x_neg = xraw[XW-1];
    x_mag = x_neg ? (64'h1_0000_0000 - {32'd0, xraw}) : {32'd0, xraw};
    y = (x_mag * x_mag + (64'd1 << (SQ_SHIFT - 1))) >> SQ_SHIFT;
    s = S_ONE;
    for (int k = NUM_TERMS - 1; k >= 1; k--) begin
      d = 64'(k) * 64'(k + 1);
      s_neg = s < 0;
      s_mag = s_neg ? 64'(-s) : 64'(s);
      t = round_product(y, s_mag, FRAC, 64'(S_CAP));
      q = (t + d / 2) / d;
      s = s_neg ? S_ONE + signed'(q) : S_ONE - signed'(q);
      if (s > S_CAP) s = S_CAP;
      if (s < -S_CAP) s = -S_CAP;
    end
    s_neg = s < 0;
    s_mag = s_neg ? 64'(-s) : 64'(s);
    r_neg = s_neg != x_neg;
    r_mag = round_product(x_mag, s_mag, FRAC - 1, r_neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
    return r_neg ? OW'(64'd0 - r_mag) : OW'(r_mag);
  endfunction

  function automatic logic [XW-1:0] random_arg();
    longint v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: v = longint'($urandom_range(32'hC000_0000)) - X_SIX;
      6, 7:             v = longint'($urandom);
      8:                v = longint'($urandom_range(1023)) * ($urandom_range(1) ? -1 : 1);
      default: begin
        if ($urandom_range(1))
          v = longint'(32'h7FFF_FFFF) - longint'($urandom_range(255));
        else
          v = -longint'(32'h8000_0000) + longint'($urandom_range(255));
      end
    endcase
    return v[XW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  task automatic send_arg(input logic [XW-1:0] x, input logic last);
    logic taken;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      arg_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    arg_if.valid   <= 1'b1;
    arg_if.x_value <= x;
    arg_if.last_in <= last;
    do begin
      @(negedge clk);
      taken = arg_if.ready;
      @(posedge clk);
    end while (taken !== 1'b1);
    j1_expected_q.push_back('{j1: j1_series(x), last: last});
  endtask

  // sender pauses until every outstanding result has been taken
  task automatic drain_results();
    arg_if.valid <= 1'b0;
    do @(posedge clk); while (j1_expected_q.size() != 0);
  endtask

  task automatic test_directed();
    logic [XW-1:0] pts[$];
    pts = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0001, 32'h1000_0000, 32'hF000_0000, 32'h6000_0000, 32'hA000_0000,
            32'h5555_5555, 32'hAAAA_AAAA};
    pts.push_back(XW'($rtoi(1.8412 * Q28)));
    pts.push_back(XW'(-$rtoi(1.8412 * Q28)));
    pts.push_back(XW'($rtoi(3.8317 * Q28)));
    pts.push_back(XW'(-$rtoi(3.8317 * Q28)));
    pts.push_back(XW'($rtoi(7.0156 * Q28)));
    pts.push_back(XW'(-$rtoi(7.5 * Q28)));
    foreach (pts[i]) send_arg(pts[i], logic'(i % 2));
    send_arg(32'h0000_0000, 1'b0);
    send_arg(32'h7FFF_FFFF, 1'b0);
  endtask

  task automatic test_random(input int unsigned n);
    repeat (n) send_arg(random_arg(), logic'($urandom_range(1)));
  endtask

  // receiver holds off while the sender keeps offering, so the pipe fills
  task automatic test_backpressure();
    rcv_hold_cycles = HOLD_CYCLES;
    repeat (FLOOD_ITEMS) send_arg(random_arg(), logic'($urandom_range(1)));
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rcv_hold_cycles != 0) begin
        rcv_hold_cycles = rcv_hold_cycles - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(negedge clk) begin : check_results
    j1_result_t want;
    if (!rst && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (j1_expected_q.size() == 0) begin
        report_mismatch("unexpected transfer j1_value", res_if.j1_value, '0);
      end else begin
        want = j1_expected_q.pop_front();
        if (res_if.j1_value !== want.j1)
          report_mismatch("j1_value", res_if.j1_value, want.j1);
        if (res_if.last_out !== want.last)
          report_mismatch("last_out", 32'(res_if.last_out), 32'(want.last));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || (arg_if.valid === 1'b1 && arg_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst            <= 1'b1;
    arg_if.valid   <= 1'b0;
    arg_if.x_value <= '0;
    arg_if.last_in <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 7;
    dst_idle_pct = 71;
    test_directed();
    drain_results();
    test_random(RANDOM_ITEMS);

    src_idle_pct = 71;
    dst_idle_pct = 7;
    test_random(RANDOM_ITEMS);
    drain_results();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_backpressure();
    test_random(RANDOM_ITEMS);

    drain_results();
    repeat (PIPE_LATENCY + 20) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
